FILE: rtl/sspc_pkg.sv
// sspc_pkg: shared types, constants and helpers of the servo slew position controller
// no dependencies; imported by every module under rtl/
`default_nettype none

package sspc_pkg;

  // block configuration
  localparam int unsigned NUM_SERVOS = 4;
  localparam int unsigned PWM_HZ     = 50;
  localparam int unsigned SRV_W      = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  // field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned PWM_W   = 12;
  localparam int unsigned US_W    = 15;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned LIM_W   = 64;

  // apb register port
  localparam int unsigned PADDR_W      = 5;
  localparam int unsigned PDATA_W      = 64;
  localparam int unsigned REG_ADDR_LSB = 3;

  // command queue between front and back
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;

  // input op codes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_TO_MIN    = 3'd1;
  localparam logic [OP_W-1:0] OP_TO_MAX    = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_ANGLE = 3'd4;
  localparam logic [OP_W-1:0] OP_REFRESH   = 3'd5;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PULSE  = 1'b1;

  // reset values
  localparam logic [LIM_W-1:0]   LIMITS_RESET    = 64'hB400_B400_B400_B400;
  localparam logic [US_W-1:0]    PULSE_MIN_RESET = 15'd1000;
  localparam logic [US_W-1:0]    PULSE_MAX_RESET = 15'd2000;
  localparam logic [MS_W-1:0]    TIMEOUT_RESET   = 16'd20;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET     = 8'd90;
  localparam logic [MS_W-1:0]    MS_SAT          = 16'hFFFF;

  // pwm datapath: shared multiplier and reciprocal constants
  localparam int unsigned MUL_AW = 26;
  localparam int unsigned MUL_BW = 24;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned DEG_SPAN      = 180;
  localparam int unsigned RCP180        = 11930464;   // floor(2^31 / 180)
  localparam int unsigned RCP180_SHIFT  = 31;
  localparam int unsigned US_PER_S      = 1000000;
  localparam int unsigned CNT_DIV       = 15625;      // 1e6 / 64, count = p * 64 / 15625
  localparam int unsigned RCPCNT        = 4398046;    // floor(2^36 / 15625)
  localparam int unsigned RCPCNT_SHIFT  = 36;

  // register index
  typedef enum logic [1:0] {
    REG_LIMITS,
    REG_PULSE_MIN,
    REG_PULSE_MAX,
    REG_TIMEOUT
  } reg_e;

  // decoded command class
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_TO_MIN,
    CMD_TO_MAX,
    CMD_STOP,
    CMD_SET,
    CMD_REFRESH,
    CMD_REJECT
  } cmd_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   servo_index;
    logic [ANGLE_W-1:0] target_angle;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   servo_id;
    logic               accepted;
    logic [ANGLE_W-1:0] angle_now;
    logic [PWM_W-1:0]   pwm_count;
    logic               last;
  } rsp_t;

  typedef struct packed {
    cmd_e               cls;
    logic [IDX_W-1:0]   idx;
    logic [ANGLE_W-1:0] angle;
  } cq_entry_t;

  typedef struct packed {
    logic [LIM_W-1:0] limits;
    logic [US_W-1:0]  pulse_min;
    logic [US_W-1:0]  pulse_max;
    logic [MS_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
  } apb_req_t;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] angle;
  } pwm_req_t;

  typedef struct packed {
    logic             done;
    logic [PWM_W-1:0] count;
  } pwm_rsp_t;

  function automatic logic [ANGLE_W-1:0] lim_min(input logic [LIM_W-1:0] tbl,
                                                 input logic [SRV_W-1:0] i);
    return tbl[16*i +: ANGLE_W];
  endfunction

  function automatic logic [ANGLE_W-1:0] lim_max(input logic [LIM_W-1:0] tbl,
                                                 input logic [SRV_W-1:0] i);
    return tbl[16*i + 8 +: ANGLE_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/servo_slew_position_controller.sv
// servo_slew_position_controller: top level of the slew limited servo controller
// depends on sspc_pkg, sspc_regs, sspc_front, sspc_back, sspc_pwm
//
//  channel   direction  handshake                       payload
//  command   in         push / full                     cmd_i (op, servo_index, target_angle)
//  result    out        empty / pop                     rsp_o (kind .. pwm_count, last)
//  config    in         psel, penable, pwrite / pready  paddr, pwdata, prdata (64 bit, 8 byte step)
//
// a servo command's status reaches the result ports once it has left the queue, passed
// the pwm states (rcp1 .. fin) on the one shared multiplier, had its count handed back
// and been loaded into the result register
// a refresh or a stepping tick walks the servos in order and puts out one result, with its
// own pwm pass, for each servo it reports; idle lanes are skipped in the scan
// a tick that does not step leaves the queue and returns nothing
// reset puts all servos at 90 degrees, clears the ms count and loads the register defaults
// a result waiting on pop holds the back end; the two entry command queue keeps taking
// commands until it fills, then full stalls the input
`default_nettype none

module servo_slew_position_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command transactions
  input  logic                             push,
  output logic                             full,
  input  sspc_pkg::cmd_t                   cmd_i,
  // result transactions
  output logic                             empty,
  input  logic                             pop,
  output sspc_pkg::rsp_t                   rsp_o,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sspc_pkg::PADDR_W-1:0]     paddr,
  input  logic [sspc_pkg::PDATA_W-1:0]     pwdata,
  output logic [sspc_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import sspc_pkg::*;

  apb_req_t   apb;
  cfg_t       cfg;
  logic       q_pop;
  logic       q_empty;
  cq_entry_t  q_head;
  pwm_req_t   pwm_req;
  pwm_rsp_t   pwm_rsp;

  // register port has no wait states
  assign pready = 1'b1;

  assign apb.psel    = psel;
  assign apb.penable = penable;
  assign apb.pwrite  = pwrite;
  assign apb.paddr   = paddr;
  assign apb.pwdata  = pwdata;

  // limits, pulse range and step timeout
  sspc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apb_i    (apb),
    .prdata_o (prdata),
    .cfg_o    (cfg)
  );

  // front end: classify each command (bad op or servo index becomes a reject) and queue it
  sspc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .cmd_i     (cmd_i),
    .q_pop_i   (q_pop),
    .q_empty_o (q_empty),
    .q_head_o  (q_head)
  );

  // back end: angle state, ms counting, per servo walk and result register
  sspc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .pwm_req_o (pwm_req),
    .pwm_rsp_i (pwm_rsp),
    .pop_i     (pop),
    .empty_o   (empty),
    .rsp_o     (rsp_o)
  );

  // angle to pulse width to 12 bit count, saturated at full scale
  sspc_pwm u_pwm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (pwm_req),
    .rsp_o  (pwm_rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/sspc_regs.sv
// sspc_regs: apb configuration registers (limits, pulse range, step timeout)
// depends on sspc_pkg
`default_nettype none

module sspc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sspc_pkg::apb_req_t              apb_i,
  output logic [sspc_pkg::PDATA_W-1:0]    prdata_o,
  output sspc_pkg::cfg_t                  cfg_o
);
  import sspc_pkg::*;

  cfg_t cfg_q;
  reg_e idx;
  logic wr_en;

  assign idx   = reg_e'(apb_i.paddr[PADDR_W-1:REG_ADDR_LSB]);
  assign wr_en = apb_i.psel && apb_i.penable && apb_i.pwrite;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limits    <= LIMITS_RESET;
      cfg_q.pulse_min <= PULSE_MIN_RESET;
      cfg_q.pulse_max <= PULSE_MAX_RESET;
      cfg_q.timeout   <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_LIMITS:    cfg_q.limits    <= apb_i.pwdata;
        REG_PULSE_MIN: cfg_q.pulse_min <= apb_i.pwdata[US_W-1:0];
        REG_PULSE_MAX: cfg_q.pulse_max <= apb_i.pwdata[US_W-1:0];
        REG_TIMEOUT:   cfg_q.timeout   <= apb_i.pwdata[MS_W-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIMITS:    prdata_o = cfg_q.limits;
      REG_PULSE_MIN: prdata_o = PDATA_W'(cfg_q.pulse_min);
      REG_PULSE_MAX: prdata_o = PDATA_W'(cfg_q.pulse_max);
      REG_TIMEOUT:   prdata_o = PDATA_W'(cfg_q.timeout);
      default:       prdata_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sspc_front.sv
// sspc_front: accepts commands, classifies them and queues them for the back end
// depends on sspc_pkg
`default_nettype none

module sspc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  sspc_pkg::cmd_t       cmd_i,
  input  logic                 q_pop_i,
  output logic                 q_empty_o,
  output sspc_pkg::cq_entry_t  q_head_o
);
  import sspc_pkg::*;

  cq_entry_t                 entries_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CQ_PTR_W:0]         cnt_q;
  cq_entry_t                 entry;
  logic                      idx_ok;
  logic                      wr_en, rd_en;

  // classify
  always_comb begin
    idx_ok       = cmd_i.servo_index < IDX_W'(NUM_SERVOS);
    entry.idx    = cmd_i.servo_index;
    entry.angle  = cmd_i.target_angle;
    unique case (cmd_i.op)
      OP_TICK:      entry.cls = CMD_TICK;
      OP_TO_MIN:    entry.cls = idx_ok ? CMD_TO_MIN : CMD_REJECT;
      OP_TO_MAX:    entry.cls = idx_ok ? CMD_TO_MAX : CMD_REJECT;
      OP_STOP:      entry.cls = idx_ok ? CMD_STOP   : CMD_REJECT;
      OP_SET_ANGLE: entry.cls = idx_ok ? CMD_SET    : CMD_REJECT;
      OP_REFRESH:   entry.cls = CMD_REFRESH;
      default:      entry.cls = CMD_REJECT;
    endcase
  end

  assign full_o    = cnt_q == (CQ_PTR_W+1)'(CQ_DEPTH);
  assign q_empty_o = cnt_q == '0;
  assign q_head_o  = entries_q[rd_ptr_q];
  assign wr_en     = push_i && !full_o;
  assign rd_en     = q_pop_i && !q_empty_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (CQ_PTR_W+1)'(wr_en) - (CQ_PTR_W+1)'(rd_en);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (CQ_PTR_W+1)'(CQ_DEPTH))
    else $error("command queue count exceeds depth");

endmodule

`default_nettype wire

FILE: rtl/sspc_pwm.sv
// sspc_pwm: multi-cycle angle to pwm count unit on one shared multiplier
// depends on sspc_pkg
`default_nettype none

module sspc_pwm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sspc_pkg::cfg_t     cfg_i,
  input  sspc_pkg::pwm_req_t req_i,
  output sspc_pkg::pwm_rsp_t rsp_o
);
  import sspc_pkg::*;

  typedef enum logic [2:0] {
    PW_IDLE,
    PW_RCP1,
    PW_CHK1,
    PW_HZ,
    PW_RCP2,
    PW_CHK2,
    PW_FIN
  } pw_state_e;

  pw_state_e           state_q;
  logic [MUL_PW-1:0]   prod_q;
  logic                neg_q;
  logic [22:0]         x_q;
  logic [15:0]         q0_q;
  logic                sat_q;
  logic [25:0]         x2_q;
  logic [PWM_W-1:0]    pwm_q;
  logic                done_q;

  logic [MUL_AW-1:0]   mul_a;
  logic [MUL_BW-1:0]   mul_b;
  logic [MUL_PW-1:0]   mul_p;
  logic signed [15:0]  diff_s;
  logic [US_W-1:0]     diff_mag;
  logic [22:0]         r1;
  logic [16:0]         q_fix;
  logic signed [17:0]  lo_s, q_s, m_s;
  logic [16:0]         m_u;
  logic [26:0]         p;
  logic [25:0]         x2;
  logic [15:0]         q0a;
  logic [12:0]         q0b;
  logic [25:0]         r2;
  logic [12:0]         cnt;

  always_comb begin
    diff_s   = signed'({1'b0, cfg_i.pulse_max}) - signed'({1'b0, cfg_i.pulse_min});
    diff_mag = diff_s[15] ? US_W'(-diff_s) : diff_s[US_W-1:0];
    // quotient by 180 with one correction step
    q0a      = prod_q[RCP180_SHIFT +: 16];
    r1       = x_q - prod_q[22:0];
    q_fix    = {1'b0, q0_q} + 17'(r1 >= 23'(DEG_SPAN));
    lo_s     = signed'({3'b000, cfg_i.pulse_min});
    q_s      = signed'({1'b0, q_fix});
    m_s      = neg_q ? lo_s - q_s : lo_s + q_s;
    m_u      = m_s[17] ? '0 : m_s[16:0];
    // pulse times rate, then scaled down to a 12 bit count
    p        = prod_q[26:0];
    x2       = {p[19:0], 6'b000000};
    q0b      = prod_q[RCPCNT_SHIFT +: 13];
    r2       = x2_q - prod_q[25:0];
    cnt      = q0_q[12:0] + 13'(r2 >= 26'(CNT_DIV));
  end

  always_comb begin
    unique case (state_q)
      PW_IDLE: begin
        mul_a = MUL_AW'(req_i.angle);
        mul_b = MUL_BW'(diff_mag);
      end
      PW_RCP1: begin
        mul_a = MUL_AW'(prod_q[22:0]);
        mul_b = MUL_BW'(RCP180);
      end
      PW_CHK1: begin
        mul_a = MUL_AW'(q0a);
        mul_b = MUL_BW'(DEG_SPAN);
      end
      PW_HZ: begin
        mul_a = MUL_AW'(m_u);
        mul_b = MUL_BW'(PWM_HZ);
      end
      PW_RCP2: begin
        mul_a = x2;
        mul_b = MUL_BW'(RCPCNT);
      end
      PW_CHK2: begin
        mul_a = MUL_AW'(q0b);
        mul_b = MUL_BW'(CNT_DIV);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_PW'(mul_a) * MUL_PW'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PW_IDLE;
      prod_q  <= '0;
      neg_q   <= 1'b0;
      x_q     <= '0;
      q0_q    <= '0;
      sat_q   <= 1'b0;
      x2_q    <= '0;
      pwm_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        PW_IDLE: begin
          if (req_i.start) begin
            prod_q  <= mul_p;
            neg_q   <= diff_s[15];
            state_q <= PW_RCP1;
          end
        end
        PW_RCP1: begin
          x_q     <= prod_q[22:0];
          prod_q  <= mul_p;
          state_q <= PW_CHK1;
        end
        PW_CHK1: begin
          q0_q    <= q0a;
          prod_q  <= mul_p;
          state_q <= PW_HZ;
        end
        PW_HZ: begin
          prod_q  <= mul_p;
          state_q <= PW_RCP2;
        end
        PW_RCP2: begin
          sat_q   <= p >= 27'(US_PER_S);
          x2_q    <= x2;
          prod_q  <= mul_p;
          state_q <= PW_CHK2;
        end
        PW_CHK2: begin
          q0_q    <= 16'(q0b);
          prod_q  <= mul_p;
          state_q <= PW_FIN;
        end
        PW_FIN: begin
          pwm_q   <= sat_q ? '1 : cnt[PWM_W-1:0];
          done_q  <= 1'b1;
          state_q <= PW_IDLE;
        end
        default: state_q <= PW_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.count = pwm_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == PW_IDLE)
    else $error("pwm unit started while busy");

endmodule

`default_nettype wire

FILE: rtl/sspc_back.sv
// sspc_back: executes queued commands, keeps servo angles and the ms count,
// drives the pwm unit and the result register; depends on sspc_pkg
`default_nettype none

module sspc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sspc_pkg::cfg_t       cfg_i,
  input  logic                 q_empty_i,
  input  sspc_pkg::cq_entry_t  q_head_i,
  output logic                 q_pop_o,
  output sspc_pkg::pwm_req_t   pwm_req_o,
  input  sspc_pkg::pwm_rsp_t   pwm_rsp_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output sspc_pkg::rsp_t       rsp_o
);
  import sspc_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_CALC,
    BK_EMIT
  } bk_state_e;

  localparam logic [SRV_W-1:0] LAST_SRV = SRV_W'(NUM_SERVOS-1);

  bk_state_e                              state_q, state_d;
  logic [NUM_SERVOS-1:0][ANGLE_W-1:0]     cur_q, cur_d;
  logic [NUM_SERVOS-1:0][ANGLE_W-1:0]     tgt_q, tgt_d;
  logic [MS_W-1:0]                        elapsed_q, elapsed_d;
  logic [NUM_SERVOS-1:0]                  mask_q, mask_d;
  logic [SRV_W-1:0]                       srv_q, srv_d;
  logic                                   single_q, single_d;
  logic                                   zero_q, zero_d;
  rsp_t                                   res_q, res_d;
  rsp_t                                   out_q, out_d;
  logic                                   out_vld_q, out_vld_d;

  logic [NUM_SERVOS-1:0][ANGLE_W-1:0]     step_ang;
  logic [NUM_SERVOS-1:0]                  step_mv;
  logic [MS_W-1:0]                        elapsed_inc;
  logic [SRV_W-1:0]                       sel;
  logic [ANGLE_W-1:0]                     sel_min, sel_max;
  logic                                   more;
  logic                                   slot_free;

  // one degree step per servo lane
  always_comb begin
    for (int j = 0; j < NUM_SERVOS; j++) begin
      step_ang[j] = cur_q[j];
      step_mv[j]  = 1'b0;
      if (tgt_q[j] > cur_q[j] && cur_q[j] < lim_max(cfg_i.limits, SRV_W'(j))) begin
        step_ang[j] = cur_q[j] + 1'b1;
        step_mv[j]  = 1'b1;
      end else if (tgt_q[j] < cur_q[j] && cur_q[j] > lim_min(cfg_i.limits, SRV_W'(j))) begin
        step_ang[j] = cur_q[j] - 1'b1;
        step_mv[j]  = 1'b1;
      end
    end
  end

  // any later servo still to report
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < NUM_SERVOS; j++) begin
      if (j > int'(srv_q) && mask_q[j]) begin
        more = 1'b1;
      end
    end
  end

  assign elapsed_inc = (elapsed_q != MS_SAT) ? elapsed_q + 1'b1 : elapsed_q;
  assign sel         = q_head_i.idx[SRV_W-1:0];
  assign sel_min     = lim_min(cfg_i.limits, sel);
  assign sel_max     = lim_max(cfg_i.limits, sel);
  assign slot_free   = !out_vld_q || pop_i;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    elapsed_d = elapsed_q;
    mask_d    = mask_q;
    srv_d     = srv_q;
    single_d  = single_q;
    zero_d    = zero_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !pop_i;
    q_pop_o   = 1'b0;
    pwm_req_o = '0;

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          unique case (q_head_i.cls)
            CMD_TICK: begin
              if (elapsed_inc > cfg_i.timeout) begin
                cur_d     = step_ang;
                mask_d    = step_mv;
                elapsed_d = '0;
                srv_d     = '0;
                single_d  = 1'b0;
                zero_d    = 1'b0;
                state_d   = (|step_mv) ? BK_SCAN : BK_IDLE;
              end else begin
                elapsed_d = elapsed_inc;
              end
            end
            CMD_REFRESH: begin
              mask_d   = '1;
              srv_d    = '0;
              single_d = 1'b0;
              zero_d   = 1'b0;
              state_d  = BK_SCAN;
            end
            CMD_TO_MIN, CMD_TO_MAX, CMD_STOP, CMD_SET: begin
              res_d.kind      = KIND_STATUS;
              res_d.servo_id  = q_head_i.idx;
              res_d.accepted  = 1'b1;
              res_d.angle_now = cur_q[sel];
              res_d.pwm_count = '0;
              res_d.last      = 1'b1;
              case (q_head_i.cls)
                CMD_TO_MIN: tgt_d[sel] = sel_min;
                CMD_TO_MAX: tgt_d[sel] = sel_max;
                CMD_STOP:   tgt_d[sel] = cur_q[sel];
                default: begin
                  if (q_head_i.angle >= sel_min && q_head_i.angle <= sel_max) begin
                    tgt_d[sel] = q_head_i.angle;
                  end else begin
                    res_d.accepted = 1'b0;
                  end
                end
              endcase
              single_d        = 1'b1;
              zero_d          = 1'b0;
              pwm_req_o.start = 1'b1;
              pwm_req_o.angle = cur_q[sel];
              state_d         = BK_CALC;
            end
            default: begin
              // rejected: bad op or servo out of range, status with zero angle and count
              res_d.kind      = KIND_STATUS;
              res_d.servo_id  = q_head_i.idx;
              res_d.accepted  = 1'b0;
              res_d.angle_now = '0;
              res_d.pwm_count = '0;
              res_d.last      = 1'b1;
              single_d        = 1'b1;
              zero_d          = 1'b1;
              state_d         = BK_EMIT;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (mask_q[srv_q]) begin
          res_d.kind      = KIND_PULSE;
          res_d.servo_id  = IDX_W'(srv_q);
          res_d.accepted  = 1'b1;
          res_d.angle_now = cur_q[srv_q];
          res_d.pwm_count = '0;
          res_d.last      = !more;
          pwm_req_o.start = 1'b1;
          pwm_req_o.angle = cur_q[srv_q];
          state_d         = BK_CALC;
        end else if (srv_q == LAST_SRV) begin
          state_d = BK_IDLE;
        end else begin
          srv_d = srv_q + 1'b1;
        end
      end
      BK_CALC: begin
        if (pwm_rsp_i.done) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_d           = res_q;
          out_d.pwm_count = zero_q ? '0 : pwm_rsp_i.count;
          out_vld_d       = 1'b1;
          if (!single_q && srv_q != LAST_SRV) begin
            srv_d   = srv_q + 1'b1;
            state_d = BK_SCAN;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cur_q     <= {NUM_SERVOS{ANGLE_RESET}};
      tgt_q     <= {NUM_SERVOS{ANGLE_RESET}};
      elapsed_q <= '0;
      mask_q    <= '0;
      srv_q     <= '0;
      single_q  <= 1'b0;
      zero_q    <= 1'b0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      tgt_q     <= tgt_d;
      elapsed_q <= elapsed_d;
      mask_q    <= mask_d;
      srv_q     <= srv_d;
      single_q  <= single_d;
      zero_q    <= zero_d;
      res_q     <= res_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign empty_o = !out_vld_q;
  assign rsp_o   = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !pop_i |=> out_vld_q && $stable(out_q))
    else $error("waiting result overwritten");

  a_angle_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cur_q) |-> $past(state_q == BK_IDLE && q_pop_o && q_head_i.cls == CMD_TICK))
    else $error("current angle changed outside a tick step");

  a_pwm_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_EMIT && !zero_q |-> $past(pwm_rsp_i.done) || $past(state_q == BK_EMIT))
    else $error("result emitted before pwm count was ready");

endmodule

`default_nettype wire
